/* rtl/core/btpc_pkg.sv */
package btpc_pkg;

  localparam int TEMP_FRAC_BITS  = 16;
  localparam int PRESS_FRAC_BITS = 6;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 48;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_TEMP_TRIM  = 2'd0,
    REG_PRESS_LOW  = 2'd1,
    REG_PRESS_MID  = 2'd2,
    REG_PRESS_HIGH = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [7:0]  t3;
  } temp_coef_t;

  typedef struct packed {
    logic [15:0] p1;
    logic [15:0] p2;
    logic [7:0]  p3;
    logic [7:0]  p4;
    logic [15:0] p5;
    logic [15:0] p6;
    logic [7:0]  p7;
    logic [7:0]  p8;
    logic [15:0] p9;
    logic [7:0]  p10;
    logic [7:0]  p11;
  } press_coef_t;

  // temperature stage result handed to the pressure pipeline
  typedef struct packed {
    logic [31:0] tq;
    logic [23:0] tout;
    logic [23:0] raw_press;
  } temp_res_t;

  function automatic temp_coef_t decode_temp(input logic [39:0] trim);
    temp_coef_t c;
    c.t1 = trim[15:0];
    c.t2 = trim[31:16];
    c.t3 = trim[39:32];
    return c;
  endfunction

  function automatic press_coef_t decode_press(input logic [47:0] lo,
                                               input logic [47:0] mid,
                                               input logic [31:0] hi);
    press_coef_t c;
    c.p1  = lo[15:0];
    c.p2  = lo[31:16];
    c.p3  = lo[39:32];
    c.p4  = lo[47:40];
    c.p5  = mid[15:0];
    c.p6  = mid[31:16];
    c.p7  = mid[39:32];
    c.p8  = mid[47:40];
    c.p9  = hi[15:0];
    c.p10 = hi[23:16];
    c.p11 = hi[31:24];
    return c;
  endfunction

endpackage

/* rtl/core/btpc_ifs.sv */
interface btpc_in_if;
  logic        valid;
  logic        ready;
  logic [23:0] raw_press;
  logic [23:0] raw_temp;

  modport source (output valid, output raw_press, output raw_temp, input ready);
  modport sink (input valid, input raw_press, input raw_temp, output ready);
endinterface

interface btpc_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] temp_out;
  logic        [22:0] press_out;

  modport source (output valid, output temp_out, output press_out, input ready);
  modport sink (input valid, input temp_out, input press_out, output ready);
endinterface

/* rtl/core/btpc_temp.sv */
module btpc_temp (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   adv,
  input  logic                   in_valid,
  input  logic [23:0]            raw_press,
  input  logic [23:0]            raw_temp,
  input  btpc_pkg::temp_coef_t   coef,
  output logic                   res_valid,
  output btpc_pkg::temp_res_t    res
);

  localparam int TOUT_SHIFT = 48 - btpc_pkg::TEMP_FRAC_BITS;
  localparam logic signed [61:0] TOUT_HALF = 62'sd1 <<< (TOUT_SHIFT - 1);
  localparam logic signed [61:0] TOUT_LO   = -(62'sd40 <<< btpc_pkg::TEMP_FRAC_BITS);
  localparam logic signed [61:0] TOUT_HI   = 62'sd85 <<< btpc_pkg::TEMP_FRAC_BITS;
  localparam logic signed [61:0] TQ_HALF   = 62'sd1 <<< 23;
  localparam logic signed [61:0] TQ_LO     = -(62'sd40 <<< 24);
  localparam logic signed [61:0] TQ_HI     = 62'sd85 <<< 24;

  logic [2:0]         v;
  logic signed [24:0] d1;
  logic signed [41:0] m1;
  logic signed [49:0] m2;
  logic signed [60:0] t48;
  logic [23:0]        rp1;
  logic [23:0]        rp2;
  logic [23:0]        rp3;

  logic signed [24:0] d_next;
  logic signed [41:0] m1_next;
  logic signed [49:0] m2_next;
  logic signed [57:0] m3;
  logic signed [60:0] t48_next;
  logic signed [61:0] tout_r;
  logic signed [61:0] tq_r;
  logic signed [61:0] tout_c;
  logic signed [61:0] tq_c;

  always_comb begin
    d_next   = $signed({1'b0, raw_temp}) - $signed({1'b0, coef.t1, 8'h00});
    m1_next  = d1 * $signed({1'b0, coef.t2});
    m2_next  = d1 * d1;
    m3       = m2 * $signed(coef.t3);
    t48_next = (61'(m1) <<< 18) + 61'(m3);
    tout_r   = (62'(t48) + TOUT_HALF) >>> TOUT_SHIFT;
    tq_r     = (62'(t48) + TQ_HALF) >>> 24;
    if (tout_r < TOUT_LO) begin
      tout_c = TOUT_LO;
    end else if (tout_r > TOUT_HI) begin
      tout_c = TOUT_HI;
    end else begin
      tout_c = tout_r;
    end
    if (tq_r < TQ_LO) begin
      tq_c = TQ_LO;
    end else if (tq_r > TQ_HI) begin
      tq_c = TQ_HI;
    end else begin
      tq_c = tq_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v         <= '0;
      res_valid <= 1'b0;
    end else if (adv) begin
      v         <= {v[1:0], in_valid};
      res_valid <= v[2];
    end
    if (adv) begin
      d1            <= d_next;
      rp1           <= raw_press;
      m1            <= m1_next;
      m2            <= m2_next;
      rp2           <= rp1;
      t48           <= t48_next;
      rp3           <= rp2;
      res.tout      <= 24'(tout_c);
      res.tq        <= 32'(tq_c);
      res.raw_press <= rp3;
    end
  end

endmodule

/* rtl/core/btpc_press.sv */
module btpc_press (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   adv,
  input  logic                   in_valid,
  input  btpc_pkg::temp_res_t    src,
  input  btpc_pkg::press_coef_t  coef,
  output logic                   res_valid,
  output logic signed [23:0]     temp_out,
  output logic [22:0]            press_out
);

  localparam int P_SHIFT = 32 - btpc_pkg::PRESS_FRAC_BITS;
  localparam logic signed [65:0] P_HALF = 66'sd1 <<< (P_SHIFT - 1);
  localparam logic signed [65:0] P_MAX  = 66'sd8388607;

  logic [4:0] v;

  // S5
  logic signed [31:0] tq5;
  logic signed [63:0] tsq;
  logic signed [48:0] p6t;
  logic signed [48:0] p2t;
  logic signed [39:0] p10t;
  logic [27:0]        pp5;
  logic [23:0]        rp5;
  logic [23:0]        tout5;
  // S6
  logic signed [48:0] p6t6;
  logic signed [48:0] p2t6;
  logic [27:0]        pp6;
  logic [23:0]        rp6;
  logic [23:0]        tout6;
  logic signed [47:0] p7t2;
  logic signed [47:0] p3t2;
  logic signed [63:0] q;
  logic signed [40:0] e;
  // S7
  logic signed [55:0] p8t3;
  logic signed [55:0] p4t3;
  logic signed [61:0] ppe;
  logic [51:0]        ppr;
  logic signed [65:0] a1;
  logic signed [39:0] c1;
  logic [23:0]        rp7;
  logic [23:0]        tout7;
  // S8
  logic signed [39:0] c;
  logic signed [65:0] a2;
  logic signed [60:0] pprp;
  logic [23:0]        rp8;
  logic [23:0]        tout8;
  // S9
  logic signed [64:0] cr;
  logic signed [65:0] a3;
  logic [23:0]        tout9;

  logic signed [31:0] tq_in;
  logic [47:0]        rsq;
  logic signed [16:0] p2m;
  logic signed [16:0] p1m;
  logic signed [63:0] tsq_next;
  logic signed [48:0] p6t_next;
  logic signed [48:0] p2t_next;
  logic signed [39:0] p10t_next;
  logic signed [39:0] tq2;
  logic signed [31:0] tq2s;
  logic signed [47:0] p7t2_next;
  logic signed [47:0] p3t2_next;
  logic signed [63:0] q_next;
  logic signed [40:0] e_next;
  logic signed [47:0] tq3;
  logic signed [32:0] e8;
  logic signed [55:0] p8t3_next;
  logic signed [55:0] p4t3_next;
  logic signed [61:0] ppe_next;
  logic [51:0]        ppr_next;
  logic signed [65:0] a1_next;
  logic signed [39:0] c1_next;
  logic signed [39:0] c_next;
  logic signed [65:0] a2_next;
  logic signed [60:0] pprp_next;
  logic signed [64:0] cr_next;
  logic signed [65:0] a3_next;
  logic signed [65:0] acc_r;
  logic signed [65:0] acc_c;

  always_comb begin
    tq_in     = $signed(src.tq);
    tsq_next  = tq_in * tq_in;
    p6t_next  = tq_in * $signed({1'b0, coef.p6});
    p2m       = 17'($signed(coef.p2)) - 17'sd16384;
    p2t_next  = tq_in * p2m;
    p10t_next = tq_in * $signed(coef.p10);
    rsq       = src.raw_press * src.raw_press;

    tq2       = 40'(tsq >>> 24);
    tq2s      = 32'(tq2 >>> 8);
    p7t2_next = tq2 * $signed(coef.p7);
    p3t2_next = tq2 * $signed(coef.p3);
    q_next    = tq2s * tq5;
    e_next    = (41'($signed(coef.p9)) <<< 24) + 41'(p10t);

    tq3       = 48'(q >>> 16);
    e8        = 33'(e >>> 8);
    p8t3_next = tq3 * $signed(coef.p8);
    p4t3_next = tq3 * $signed(coef.p4);
    ppe_next  = $signed({1'b0, pp6}) * e8;
    ppr_next  = pp6 * rp6;
    a1_next   = (66'($signed({1'b0, coef.p5})) <<< 35) + (66'(p6t6) <<< 2) + 66'(p7t2);
    p1m       = 17'($signed(coef.p1)) - 17'sd16384;
    c1_next   = (40'(p1m) <<< 20) + 40'(p2t6 >>> 13) + 40'(p3t2 >>> 16);

    c_next    = c1 + 40'(p4t3 >>> 21);
    a2_next   = a1 + 66'(p8t3 >>> 7) + 66'(ppe >>> 12);
    pprp_next = $signed({1'b0, ppr}) * $signed(coef.p11);

    cr_next   = c * $signed({1'b0, rp8});
    a3_next   = a2 + 66'(pprp >>> 13);

    acc_r     = (a3 + 66'(cr >>> 8) + P_HALF) >>> P_SHIFT;
    if (acc_r < 66'sd0) begin
      acc_c = '0;
    end else if (acc_r > P_MAX) begin
      acc_c = P_MAX;
    end else begin
      acc_c = acc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v         <= '0;
      res_valid <= 1'b0;
    end else if (adv) begin
      v         <= {v[3:0], in_valid};
      res_valid <= v[4];
    end
    if (adv) begin
      tq5       <= tq_in;
      tsq       <= tsq_next;
      p6t       <= p6t_next;
      p2t       <= p2t_next;
      p10t      <= p10t_next;
      pp5       <= rsq[47:20];
      rp5       <= src.raw_press;
      tout5     <= src.tout;

      p6t6      <= p6t;
      p2t6      <= p2t;
      pp6       <= pp5;
      rp6       <= rp5;
      tout6     <= tout5;
      p7t2      <= p7t2_next;
      p3t2      <= p3t2_next;
      q         <= q_next;
      e         <= e_next;

      p8t3      <= p8t3_next;
      p4t3      <= p4t3_next;
      ppe       <= ppe_next;
      ppr       <= ppr_next;
      a1        <= a1_next;
      c1        <= c1_next;
      rp7       <= rp6;
      tout7     <= tout6;

      c         <= c_next;
      a2        <= a2_next;
      pprp      <= pprp_next;
      rp8       <= rp7;
      tout8     <= tout7;

      cr        <= cr_next;
      a3        <= a3_next;
      tout9     <= tout8;

      temp_out  <= $signed(tout9);
      press_out <= 23'(acc_c);
    end
  end

endmodule

/* rtl/core/baro_temp_press_compensation.sv */
// Compensates one raw temperature/pressure pair per transfer. Fully pipelined
// (4 temperature stages, 6 pressure stages ending in the output register):
// a new pair is taken every cycle unless the output is held off; then the
// whole pipeline stalls and sample.ready drops. temp_out is in 1/65536 degC
// clamped to -40..85 degC, press_out in 1/64 Pa clamped to 0..2^23-1. Reset
// clears the trim registers. The user must write them (cfg_we, cfg_index,
// cfg_data) only while the pipeline is empty; the block does not enforce it.
module baro_temp_press_compensation (
  input  logic                                clk,
  input  logic                                rst,
  btpc_in_if.sink                             sample,
  btpc_out_if.source                          result,
  input  logic                                cfg_we,
  input  logic [btpc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [btpc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic [39:0] temp_trim;
  logic [47:0] press_trim_low;
  logic [47:0] press_trim_mid;
  logic [31:0] press_trim_high;

  logic                  adv;
  logic                  t_valid;
  btpc_pkg::temp_res_t   t_res;
  btpc_pkg::temp_coef_t  tcoef;
  btpc_pkg::press_coef_t pcoef;

  assign adv          = !result.valid || result.ready;
  assign sample.ready = adv;
  assign tcoef        = btpc_pkg::decode_temp(temp_trim);
  assign pcoef        = btpc_pkg::decode_press(press_trim_low, press_trim_mid,
                                               press_trim_high);

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_trim       <= '0;
      press_trim_low  <= '0;
      press_trim_mid  <= '0;
      press_trim_high <= '0;
    end else if (cfg_we) begin
      unique case (btpc_pkg::cfg_reg_t'(cfg_index))
        btpc_pkg::REG_TEMP_TRIM:  temp_trim       <= cfg_data[39:0];
        btpc_pkg::REG_PRESS_LOW:  press_trim_low  <= cfg_data[47:0];
        btpc_pkg::REG_PRESS_MID:  press_trim_mid  <= cfg_data[47:0];
        btpc_pkg::REG_PRESS_HIGH: press_trim_high <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  btpc_temp u_temp (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (sample.valid),
    .raw_press (sample.raw_press),
    .raw_temp  (sample.raw_temp),
    .coef      (tcoef),
    .res_valid (t_valid),
    .res       (t_res)
  );

  btpc_press u_press (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (t_valid),
    .src       (t_res),
    .coef      (pcoef),
    .res_valid (result.valid),
    .temp_out  (result.temp_out),
    .press_out (result.press_out)
  );

`ifndef ASSERT_OFF
  a_reset_clears: assert property (@(posedge clk) rst |=> !result.valid)
    else $error("result valid after reset");

  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.ready) |-> !sample.ready)
    else $error("sample taken while result stalled");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !result.valid |-> sample.ready)
    else $error("not ready with empty output");
`endif

endmodule

/* tb/sv/tb_baro_temp_press_compensation.sv */
module tb_baro_temp_press_compensation;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY    = 10;
  localparam int STALL_MAX  = 5000;
  localparam int IDLE_PCT   = 34;

  typedef struct {
    logic signed [23:0] temp;
    logic [22:0]        press;
  } comp_result_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [btpc_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [btpc_pkg::CFG_DATA_W-1:0]  cfg_data;

  btpc_in_if  sample_ch ();
  btpc_out_if result_ch ();

  baro_temp_press_compensation i_dut (
    .clk       (clk),
    .rst       (rst),
    .sample    (sample_ch),
    .result    (result_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  logic [39:0] temp_trim_q;
  logic [47:0] press_lo_q;
  logic [47:0] press_mid_q;
  logic [31:0] press_hi_q;

  comp_result_t comp_expected[$];
  int  mismatches = 0;
  int  stall_cycles = 0;
  bit  steady_flow;

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic longint floor_sh(longint x, int s);
    return x >>> s;
  endfunction

  function automatic longint round_sh(longint x, int s);
    if (s == 0) return x;
    return (x + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clip(longint x, longint lo, longint hi);
    return x < lo ? lo : (x > hi ? hi : x);
  endfunction

  function automatic comp_result_t predict_compensation(logic [23:0] raw_p, logic [23:0] raw_t);
    comp_result_t r;
    longint t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, p10, p11;
    longint rp, rt, d, t48, tout, tq, tq2, tq3, acc, c, pp, e, pout;
    t1  = longint'({1'b0, temp_trim_q[15:0]});
    t2  = longint'({1'b0, temp_trim_q[31:16]});
    t3  = longint'($signed(temp_trim_q[39:32]));
    p1  = longint'($signed(press_lo_q[15:0]));
    p2  = longint'($signed(press_lo_q[31:16]));
    p3  = longint'($signed(press_lo_q[39:32]));
    p4  = longint'($signed(press_lo_q[47:40]));
    p5  = longint'({1'b0, press_mid_q[15:0]});
    p6  = longint'({1'b0, press_mid_q[31:16]});
    p7  = longint'($signed(press_mid_q[39:32]));
    p8  = longint'($signed(press_mid_q[47:40]));
    p9  = longint'($signed(press_hi_q[15:0]));
    p10 = longint'($signed(press_hi_q[23:16]));
    p11 = longint'($signed(press_hi_q[31:24]));
    rp  = longint'({1'b0, raw_p});
    rt  = longint'({1'b0, raw_t});
    d   = rt - t1 * 256;
    t48 = d * t2 * 262144 + d * d * t3;
    tout = clip(round_sh(t48, 48 - btpc_pkg::TEMP_FRAC_BITS),
                -40 * (longint'(1) <<< btpc_pkg::TEMP_FRAC_BITS),
                85 * (longint'(1) <<< btpc_pkg::TEMP_FRAC_BITS));
    tq  = clip(round_sh(t48, 24), -40 * (longint'(1) <<< 24), 85 * (longint'(1) <<< 24));
    tq2 = floor_sh(tq * tq, 24);
    tq3 = floor_sh(floor_sh(tq2, 8) * tq, 16);
    acc = p5 * (longint'(1) <<< 35) + p6 * tq * 4 + p7 * tq2 + floor_sh(p8 * tq3, 7);
    c   = (p1 - 16384) * (longint'(1) <<< 20) + floor_sh((p2 - 16384) * tq, 13)
        + floor_sh(p3 * tq2, 16) + floor_sh(p4 * tq3, 21);
    acc += floor_sh(c * rp, 8);
    pp  = (rp * rp) >> 20;
    e   = p9 * (longint'(1) <<< 24) + p10 * tq;
    acc += floor_sh(pp * floor_sh(e, 8), 12);
    acc += floor_sh(pp * rp * p11, 13);
    pout = clip(round_sh(acc, 32 - btpc_pkg::PRESS_FRAC_BITS), 0, 64'h7FFFFF);
    r.temp  = tout[23:0];
    r.press = pout[22:0];
    return r;
  endfunction

  // result ready with random backpressure, held high during steady-flow phases
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    comp_result_t exp_r;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (comp_expected.size() == 0) begin
        $error("unexpected result transfer: temp_out=%0d press_out=%0d",
               result_ch.temp_out, result_ch.press_out);
        mismatches++;
      end else begin
        exp_r = comp_expected.pop_front();
        if (result_ch.temp_out !== exp_r.temp) begin
          $error("temp_out: expected %0d, actual %0d", exp_r.temp, result_ch.temp_out);
          mismatches++;
        end
        if (result_ch.press_out !== exp_r.press) begin
          $error("press_out: expected %0d, actual %0d", exp_r.press, result_ch.press_out);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_MAX) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_sample(logic [23:0] raw_p, logic [23:0] raw_t);
    if (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
      sample_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    sample_ch.valid     <= 1'b1;
    sample_ch.raw_press <= raw_p;
    sample_ch.raw_temp  <= raw_t;
    do @(posedge clk); while (!sample_ch.ready);
    comp_expected.push_back(predict_compensation(raw_p, raw_t));
  endtask

  task automatic drain();
    sample_ch.valid <= 1'b0;
    do @(posedge clk); while (comp_expected.size() != 0);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_reg(btpc_pkg::cfg_reg_t idx, logic [btpc_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      btpc_pkg::REG_TEMP_TRIM:  temp_trim_q = data[39:0];
      btpc_pkg::REG_PRESS_LOW:  press_lo_q  = data[47:0];
      btpc_pkg::REG_PRESS_MID:  press_mid_q = data[47:0];
      btpc_pkg::REG_PRESS_HIGH: press_hi_q  = data[31:0];
      default: ;
    endcase
  endtask

  // bits above the temp and high-pressure register widths are driven too; the block must drop them
  task automatic load_trims(logic [39:0] tt, logic [47:0] lo, logic [47:0] mid, logic [31:0] hi);
    drain();
    write_reg(btpc_pkg::REG_TEMP_TRIM, {8'($urandom), tt});
    write_reg(btpc_pkg::REG_PRESS_LOW, lo);
    write_reg(btpc_pkg::REG_PRESS_MID, mid);
    write_reg(btpc_pkg::REG_PRESS_HIGH, {16'($urandom), hi});
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  localparam logic [39:0] TYP_TEMP = {8'shF9, 16'd19102, 16'd27505};
  localparam logic [47:0] TYP_LO   = {8'shFD, 8'sd10, 16'd18000, 16'd20000};
  localparam logic [47:0] TYP_MID  = {8'shFA, 8'sd3, 16'd24000, 16'd25000};
  localparam logic [31:0] TYP_HI   = {8'shF4, 8'sd4, 16'hFA24};

  function automatic logic [23:0] near_t1(logic [39:0] tt);
    longint v;
    v = longint'({1'b0, tt[15:0]}) * 256 + longint'($urandom_range(0, 2097152)) - 1048576;
    return 24'(clip(v, 0, 24'hFFFFFF));
  endfunction

  task automatic test_zero_trims();
    send_sample(24'h000000, 24'h000000);
    send_sample(24'hFFFFFF, 24'hFFFFFF);
    send_sample(24'h800000, 24'h7FFFFF);
    send_sample(24'h555555, 24'hAAAAAA);
  endtask

  task automatic test_trim_extremes();
    load_trims('1, '1, '1, '1);
    send_sample(24'h000000, 24'h000000);
    send_sample(24'hFFFFFF, 24'hFFFFFF);
    send_sample(24'hFFFFFF, 24'h000000);
    load_trims({8'h80, 16'hFFFF, 16'h0000}, {8'h80, 8'h80, 16'h8000, 16'h8000},
               {8'h80, 8'h80, 16'hFFFF, 16'hFFFF}, {8'h80, 8'h80, 16'h8000});
    send_sample(24'hFFFFFF, 24'hFFFFFF);
    send_sample(24'h000000, 24'hFFFFFF);
    load_trims({8'h7F, 16'hFFFF, 16'h0000}, {8'h7F, 8'h7F, 16'h7FFF, 16'h7FFF},
               {8'h7F, 8'h7F, 16'h0000, 16'h0000}, {8'h7F, 8'h7F, 16'h7FFF});
    send_sample(24'hFFFFFF, 24'hFFFFFF);
    send_sample(24'h000000, 24'h000001);
  endtask

  task automatic test_typical_directed();
    load_trims(TYP_TEMP, TYP_LO, TYP_MID, TYP_HI);
    send_sample(24'd6_700_000, 24'd27505 * 24'd256);
    send_sample(24'd6_700_000, 24'd27505 * 24'd256 + 24'd400_000);
    send_sample(24'd6_700_000, 24'd27505 * 24'd256 - 24'd400_000);
    send_sample(24'hFFFFFF, 24'd27505 * 24'd256 + 24'd1_000_000);
    send_sample(24'h000000, 24'd27505 * 24'd256 - 24'd1_500_000);
    send_sample(24'hFFFFFF, 24'h000000);
    send_sample(24'h000000, 24'hFFFFFF);
  endtask

  task automatic test_random_phase(int n_items, bit wild_trims, bit no_idle);
    logic [39:0] tt;
    logic [47:0] lo, mid;
    logic [31:0] hi;
    if (wild_trims) begin
      tt = {8'($urandom), 32'($urandom)};
      lo = {16'($urandom), 32'($urandom)};
      mid = {16'($urandom), 32'($urandom)};
      hi = 32'($urandom);
    end else begin
      tt  = TYP_TEMP ^ {5'd0, 3'($urandom), 16'($urandom_range(0, 1023)),
                        16'($urandom_range(0, 2047))};
      lo  = TYP_LO ^ {5'd0, 3'($urandom), 5'd0, 3'($urandom), 16'($urandom_range(0, 4095)),
                      16'($urandom_range(0, 4095))};
      mid = TYP_MID ^ {5'd0, 3'($urandom), 5'd0, 3'($urandom), 16'($urandom_range(0, 4095)),
                       16'($urandom_range(0, 4095))};
      hi  = TYP_HI ^ {5'd0, 3'($urandom), 5'd0, 3'($urandom), 16'($urandom_range(0, 1023))};
    end
    load_trims(tt, lo, mid, hi);
    steady_flow = no_idle;
    for (int k = 0; k < n_items; k++) begin
      if ($urandom_range(9) < 8)
        send_sample(24'($urandom), near_t1(tt));
      else
        send_sample(24'($urandom), 24'($urandom));
    end
    steady_flow = 1'b0;
  endtask

  task automatic test_pause_until_empty();
    for (int k = 0; k < 40; k++) begin
      send_sample(24'($urandom), near_t1(temp_trim_q));
      if (k % 13 == 12) drain();
    end
  endtask

  initial begin
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_index       = btpc_pkg::REG_TEMP_TRIM;
    cfg_data        = '0;
    sample_ch.valid = 1'b0;
    sample_ch.raw_press = '0;
    sample_ch.raw_temp  = '0;
    steady_flow     = 1'b0;
    temp_trim_q = '0;
    press_lo_q  = '0;
    press_mid_q = '0;
    press_hi_q  = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_zero_trims();
    test_trim_extremes();
    test_typical_directed();
    test_random_phase(350, 1'b0, 1'b0);
    test_random_phase(300, 1'b0, 1'b1);
    test_random_phase(300, 1'b0, 1'b0);
    test_random_phase(200, 1'b1, 1'b0);
    test_pause_until_empty();
    test_random_phase(350, 1'b0, 1'b0);
    test_random_phase(150, 1'b1, 1'b0);
    test_random_phase(200, 1'b0, 1'b0);
    drain();

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
